>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Request and status codes, cell commands and the sizing of the cell row.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         count_t;

	localparam data_t EMPTY_VALUE = -32'sd1;
	localparam count_t FULL_COUNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_QUERY      = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	// What every cell does on the next edge
	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_SHIFT_UP   = 3'd1, // take the left neighbor (push front)
		CELL_SHIFT_DOWN = 3'd2, // take the right neighbor (pop front)
		CELL_APPEND     = 3'd3, // first free cell loads the value (push back)
		CELL_TRIM       = 3'd4  // last held cell drops out (pop back)
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    push_value;
	} cell_ctrl_t;

endpackage

>>> rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_if: request and response channels of the double-ended queue
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface dq_req_if;
	logic                valid;
	logic                ready;
	logic [2:0]          req_type;
	dq_pkg::data_t       push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface dq_rsp_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	dq_pkg::data_t        front_value;
	dq_pkg::data_t        back_value;
	dq_pkg::count_t       entry_count;
	logic                 is_empty;

	modport source (output valid, output status, output front_value,
		output back_value, output entry_count, output is_empty, input ready);
	modport sink   (input valid, input status, input front_value,
		input back_value, input entry_count, input is_empty, output ready);
endinterface

>>> rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue's cell row
// Holds one entry and its valid bit; takes data from either neighbor.
// ----------------------------------------------------------------------------
module dq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dq_pkg::cell_ctrl_t ctrl,
	input  logic               left_valid,
	input  dq_pkg::data_t      left_data,
	input  logic               right_valid,
	input  dq_pkg::data_t      right_data,
	output logic               valid,
	output dq_pkg::data_t      data
);

	logic          valid_q;
	dq_pkg::data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				dq_pkg::CELL_SHIFT_UP:   valid_q <= left_valid;
				dq_pkg::CELL_SHIFT_DOWN: valid_q <= right_valid;
				dq_pkg::CELL_APPEND:     valid_q <= valid_q | left_valid;
				dq_pkg::CELL_TRIM:       valid_q <= valid_q & right_valid;
				default:                 valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			dq_pkg::CELL_SHIFT_UP:   data_q <= left_data;
			dq_pkg::CELL_SHIFT_DOWN: data_q <= right_data;
			dq_pkg::CELL_APPEND: begin
				if (left_valid && !valid_q) begin
					data_q <= ctrl.push_value;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Entries sit in a row of cells, front in cell 0, packed toward the front.
//
//   channel | dir | payload
//   req     | in  | req_type, push_value
//   rsp     | out | status, front_value, back_value, entry_count, is_empty
//
// One request per cycle; the response is valid the cycle after the request.
// The cell row moves on each edge that accepts a push or pop it can serve; a pending
// response that is not taken blocks the next request (req.ready follows rsp.ready then).
// Reset empties the row at once through the cell valid bits.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic     clk,
	input  logic     arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);

	logic                 cell_valid [dq_pkg::DEPTH];
	dq_pkg::data_t        cell_data  [dq_pkg::DEPTH];
	logic                 cell_last  [dq_pkg::DEPTH];
	dq_pkg::cell_ctrl_t   ctrl;

	dq_pkg::count_t       count_q;
	logic                 pend_q;
	dq_pkg::status_t      status_q;

	logic                 accept;
	logic                 full;
	logic                 empty;
	dq_pkg::status_t      status_d;
	dq_pkg::data_t        back_sel;

	assign full   = (count_q == dq_pkg::FULL_COUNT);
	assign empty  = !cell_valid[0];
	assign req.ready = !pend_q || rsp.ready;
	assign accept = req.valid && req.ready;

	always_comb begin
		status_d       = dq_pkg::ST_OK;
		ctrl.op        = dq_pkg::CELL_HOLD;
		ctrl.push_value = req.push_value;
		case (req.req_type)
			dq_pkg::REQ_PUSH_BACK: begin
				if (full) status_d = dq_pkg::ST_OVER;
				else      ctrl.op  = dq_pkg::CELL_APPEND;
			end
			dq_pkg::REQ_PUSH_FRONT: begin
				if (full) status_d = dq_pkg::ST_OVER;
				else      ctrl.op  = dq_pkg::CELL_SHIFT_UP;
			end
			dq_pkg::REQ_POP_FRONT: begin
				if (empty) status_d = dq_pkg::ST_UNDER;
				else       ctrl.op  = dq_pkg::CELL_SHIFT_DOWN;
			end
			dq_pkg::REQ_POP_BACK: begin
				if (empty) status_d = dq_pkg::ST_UNDER;
				else       ctrl.op  = dq_pkg::CELL_TRIM;
			end
			default: ; // query and unused codes leave the row alone
		endcase
		if (!accept) begin
			ctrl.op = dq_pkg::CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
			end else if (rsp.ready) begin
				pend_q <= 1'b0;
			end
			case (ctrl.op)
				dq_pkg::CELL_APPEND,
				dq_pkg::CELL_SHIFT_UP:   count_q <= count_q + dq_pkg::count_t'(1);
				dq_pkg::CELL_SHIFT_DOWN,
				dq_pkg::CELL_TRIM:       count_q <= count_q - dq_pkg::count_t'(1);
				default:                 count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
		logic          lv;
		logic          rv;
		dq_pkg::data_t ld;
		dq_pkg::data_t rd;

		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ld = req.push_value;
		end else begin : g_mid_l
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == dq_pkg::DEPTH - 1) begin : g_end
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		assign cell_last[i] = cell_valid[i] && !rv;

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.data        (cell_data[i])
		);
	end

	// exactly one cell is last when the row is not empty
	always_comb begin
		back_sel = '0;
		for (int i = 0; i < dq_pkg::DEPTH; i++) begin
			if (cell_last[i]) begin
				back_sel = back_sel | cell_data[i];
			end
		end
	end

	assign rsp.valid       = pend_q;
	assign rsp.status      = status_q;
	assign rsp.front_value = empty ? dq_pkg::EMPTY_VALUE : cell_data[0];
	assign rsp.back_value  = empty ? dq_pkg::EMPTY_VALUE : back_sel;
	assign rsp.entry_count = count_q;
	assign rsp.is_empty    = empty;

endmodule

>>> rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [1:0]         status,
	input dq_pkg::data_t      front_value,
	input dq_pkg::data_t      back_value,
	input dq_pkg::count_t     entry_count,
	input logic               is_empty
);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count <= dq_pkg::FULL_COUNT))
		else $error("count beyond depth");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && is_empty) |->
			(front_value == dq_pkg::EMPTY_VALUE && back_value == dq_pkg::EMPTY_VALUE))
		else $error("empty queue shows values");

	a_status_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((status != dq_pkg::ST_UNDER || is_empty) &&
			(status != dq_pkg::ST_OVER || entry_count == dq_pkg::FULL_COUNT)))
		else $error("status does not match occupancy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) &&
			$stable(front_value) && $stable(back_value) && $stable(entry_count)))
		else $error("stalled response changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.front_value (rsp.front_value),
	.back_value  (rsp.back_value),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double-ended queue
// A short table of directed requests (reset state, empty pops, extreme values,
// unused codes, fill to full and overflow), then random requests in segments
// that lean toward filling, draining or mixing. Every response is checked
// against a shadow ring predictor. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import dq_pkg::*;

	localparam int N_RANDOM    = 1875;
	localparam int N_CALM      = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 4;

	// request codes the block treats as query only
	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	typedef struct packed {
		status_t status;
		data_t   front;
		data_t   back;
		count_t  count;
		logic    empty;
	} deque_rsp_t;

	typedef enum logic [1:0] {
		FIX_NONE   = 2'd0,
		FIX_ALL    = 2'd1,
		FIX_STATUS = 2'd2
	} fix_t;

	typedef struct packed {
		logic [2:0] code;
		data_t      value;
		fix_t       fix;
		deque_rsp_t want;
	} step_t;

	localparam deque_rsp_t EMPTY_OK =
		'{ST_OK, EMPTY_VALUE, EMPTY_VALUE, count_t'(0), 1'b1};
	localparam deque_rsp_t EMPTY_UNDER =
		'{ST_UNDER, EMPTY_VALUE, EMPTY_VALUE, count_t'(0), 1'b1};
	localparam deque_rsp_t OVER_ONLY = '{ST_OVER, '0, '0, '0, 1'b0};

	localparam int N_DIRECTED = 25;
	localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;
	localparam step_t DIRECTED [0:N_DIRECTED-1] = '{
		'{REQ_QUERY,      32'sh0000_0000, FIX_ALL,    EMPTY_OK},
		'{REQ_POP_FRONT,  32'sh1234_5678, FIX_ALL,    EMPTY_UNDER},
		'{REQ_POP_BACK,   32'sh1234_5678, FIX_ALL,    EMPTY_UNDER},
		'{REQ_PUSH_BACK,  32'sh7FFF_FFFF, FIX_NONE,   '0},
		'{REQ_POP_BACK,   32'sh0000_0000, FIX_ALL,    EMPTY_OK},
		'{REQ_PUSH_FRONT, 32'sh8000_0000, FIX_NONE,   '0},
		'{REQ_SPARE_5,    32'shFFFF_FFFF, FIX_NONE,   '0},
		'{REQ_SPARE_6,    32'sh5555_5555, FIX_NONE,   '0},
		'{REQ_SPARE_7,    32'shAAAA_AAAA, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'shFFFF_FFFF, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh0000_0000, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'sh0000_0001, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh7FFF_FFFF, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'sh8000_0000, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh5555_5555, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'shAAAA_AAAA, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh0F0F_0F0F, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'shF0F0_F0F0, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh0000_FFFF, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'shFFFF_0000, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh0000_0002, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'shFFFF_FFFE, FIX_NONE,   '0},
		'{REQ_PUSH_FRONT, 32'sh1357_9BDF, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'sh2468_ACE0, FIX_NONE,   '0},
		'{REQ_PUSH_BACK,  32'sh0BAD_F00D, FIX_STATUS, OVER_ONLY}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   mismatches = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_over = 0;
	int   n_under = 0;
	int   n_full = 0;

	// shadow ring: head points at the front, tail one past the back
	data_t shadow_cells [DEPTH];
	int    shadow_head = 0;
	int    shadow_tail = 0;
	int    shadow_count = 0;

	// expected responses in request order
	deque_rsp_t exp_fifo [N_ITEMS];
	int         exp_wr = 0;
	int         exp_rd = 0;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	function automatic int ring_after(input int idx);
		return (idx == DEPTH - 1) ? 0 : idx + 1;
	endfunction

	function automatic int ring_before(input int idx);
		return (idx == 0) ? DEPTH - 1 : idx - 1;
	endfunction

	task automatic apply_to_shadow(input logic [2:0] code, input data_t value,
		output deque_rsp_t r);
		r = '0;
		r.status = ST_OK;
		case (code)
			REQ_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_OVER;
				end else begin
					shadow_cells[shadow_tail] = value;
					shadow_tail = ring_after(shadow_tail);
					shadow_count++;
				end
			end
			REQ_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_OVER;
				end else begin
					shadow_head = ring_before(shadow_head);
					shadow_cells[shadow_head] = value;
					shadow_count++;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.status = ST_UNDER;
				end else begin
					shadow_head = ring_after(shadow_head);
					shadow_count--;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_UNDER;
				end else begin
					shadow_tail = ring_before(shadow_tail);
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		if (shadow_count != 0) begin
			r.front = shadow_cells[shadow_head];
			r.back  = shadow_cells[ring_before(shadow_tail)];
		end else begin
			r.front = EMPTY_VALUE;
			r.back  = EMPTY_VALUE;
		end
		r.count = count_t'(shadow_count);
		r.empty = (shadow_count == 0);
		if (r.status == ST_OVER) n_over++;
		if (r.status == ST_UNDER) n_under++;
		if (shadow_count == DEPTH) n_full++;
	endtask

	// holds valid high across back-to-back requests; drops it only for a gap
	task automatic send_request(input logic [2:0] code, input data_t value);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= code;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		n_sent++;
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return EMPTY_VALUE;
			3: return 32'sh0000_0000;
			4: return data_t'($urandom_range(0, 255));
			default: return data_t'($urandom);
		endcase
	endfunction

	// fill leans on pushes, drain on pops, mixed spreads over every code
	function automatic logic [2:0] pick_code(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 40) return REQ_PUSH_BACK;
				if (r < 80) return REQ_PUSH_FRONT;
				if (r < 88) return REQ_POP_FRONT;
				if (r < 96) return REQ_POP_BACK;
				return REQ_QUERY;
			end
			1: begin
				if (r < 40) return REQ_POP_FRONT;
				if (r < 80) return REQ_POP_BACK;
				if (r < 88) return REQ_PUSH_BACK;
				if (r < 96) return REQ_PUSH_FRONT;
				return REQ_QUERY;
			end
			default: begin
				if (r < 22) return REQ_PUSH_BACK;
				if (r < 44) return REQ_PUSH_FRONT;
				if (r < 66) return REQ_POP_FRONT;
				if (r < 88) return REQ_POP_BACK;
				if (r < 94) return REQ_QUERY;
				if (r < 96) return REQ_SPARE_5;
				if (r < 98) return REQ_SPARE_6;
				return REQ_SPARE_7;
			end
		endcase
	endfunction

	// response side: stall bursts, none once the run goes calm
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		deque_rsp_t got;
		deque_rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = status_t'(rsp_ch.status);
			got.front  = rsp_ch.front_value;
			got.back   = rsp_ch.back_value;
			got.count  = rsp_ch.entry_count;
			got.empty  = rsp_ch.is_empty;
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0d] response with none expected: %s",
						cycles, $sformatf("st=%0d f=%0d b=%0d n=%0d e=%0b",
						got.status, got.front, got.back, got.count, got.empty));
			end else begin
				exp_rsp = exp_fifo[exp_rd];
				exp_rd++;
				n_checked++;
				if (got.status !== exp_rsp.status || got.front !== exp_rsp.front ||
					got.back !== exp_rsp.back || got.count !== exp_rsp.count ||
					got.empty !== exp_rsp.empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0d] mismatch exp %s got %s", cycles,
							$sformatf("st=%0d f=%0d b=%0d n=%0d e=%0b",
							exp_rsp.status, exp_rsp.front, exp_rsp.back,
							exp_rsp.count, exp_rsp.empty),
							$sformatf("st=%0d f=%0d b=%0d n=%0d e=%0b",
							got.status, got.front, got.back, got.count,
							got.empty));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, exp_wr - exp_rd);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		deque_rsp_t pred;
		step_t      row;
		logic [2:0] code;
		int         mode;
		int         seg_left;

		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_QUERY;
		req_ch.push_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			send_request(row.code, row.value);
			apply_to_shadow(row.code, row.value, pred);
			case (row.fix)
				FIX_ALL:    pred = row.want;
				FIX_STATUS: pred.status = row.want.status;
				default: begin
				end
			endcase
			exp_fifo[exp_wr] = pred;
			exp_wr++;
		end

		mode = 2;
		seg_left = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - N_CALM) calm = 1'b1;
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(8, 40);
			end
			seg_left--;
			code = pick_code(mode);
			row.value = pick_value();
			send_request(code, row.value);
			apply_to_shadow(code, row.value, pred);
			exp_fifo[exp_wr] = pred;
			exp_wr++;
		end
		req_ch.valid <= 1'b0;

		while (exp_rd != exp_wr) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d requests, checked %0d responses", n_sent, n_checked);
		$display("queue hit full %0d times; %0d overflow and %0d underflow responses",
			n_full, n_over, n_under);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
sim/tb_top.sv
